// File: src/sss_pkg.sv
// Shared types and constants for the simplified silhouette scorer.
package sss_pkg;
  localparam int DIST_W = 32;
  localparam int SIL_W = 18;
  localparam int SUM_W = 30;
  localparam int IDX_W = 12;
  localparam logic [1:0] KIND_OBJ = 2'd0;
  localparam logic [1:0] KIND_CLU = 2'd1;
  localparam logic [1:0] KIND_ALL = 2'd2;
  localparam logic signed [SIL_W-1:0] ONE_Q = 18'sd65536;

  typedef struct packed {
    logic load_obj;
    logic start_div;
    logic sel_avg;
    logic [2:0] avg_idx;
    logic avg_all;
    logic accum;
    logic clear;
  } sss_cmd_t;

  typedef struct packed {
    logic div_done;
    logic obj_err;
  } sss_sts_t;
endpackage

// File: src/sss_div.sv
// Iterative restoring divider, one quotient bit per cycle, signed numerator.
module sss_div import sss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic signed [48:0] num,
  input  logic [31:0]       den,
  output logic              done,
  output logic signed [SIL_W-1:0] quo
);
  logic [47:0] mag_r, mag_nxt;
  logic [31:0] den_r;
  logic [32:0] rem_r, rem_nxt;
  logic [47:0] q_r, q_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, busy_r, busy_nxt, done_r, done_nxt, zero_r;
  logic [33:0] sh, diff;
  logic [48:0] qs;

  always_comb begin
    sh = {rem_r, mag_r[47]};
    diff = sh - {2'b0, den_r};
    mag_nxt = {mag_r[46:0], 1'b0};
    rem_nxt = diff[33] ? sh[32:0] : diff[32:0];
    q_nxt = {q_r[46:0], ~diff[33]};
    cnt_nxt = cnt_r - 6'd1;
    busy_nxt = busy_r && (cnt_r != 6'd1);
    done_nxt = busy_r && (cnt_r == 6'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 6'd48;
      neg_r  <= num[48];
      mag_r  <= num[48] ? 48'(-num) : num[47:0];
      den_r  <= den;
      zero_r <= (den == 32'd0);
      rem_r  <= '0;
      q_r    <= '0;
    end else begin
      done_r <= done_nxt;
      busy_r <= busy_nxt;
      if (busy_r) begin
        mag_r <= mag_nxt;
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_comb begin
    qs = (q_r > 48'd65536) ? 49'd65536 : {1'b0, q_r};
    if (zero_r) qs = '0;
    quo = neg_r ? SIL_W'(-$signed(qs)) : SIL_W'(qs);
  end
  assign done = done_r;
endmodule

// File: src/sss_datapath.sv
// Datapath: distance selection, accumulators and divider.
module sss_datapath import sss_pkg::*; #(
  parameter int MAX_CLUSTERS = 8,
  parameter int MAX_OBJECTS = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  sss_cmd_t cmd,
  output sss_sts_t sts,
  input  logic [3:0] cnt,
  input  logic [DIST_W-1:0] dists [MAX_CLUSTERS],
  input  logic [2:0] pred,
  output logic signed [SIL_W-1:0] quo,
  output logic [IDX_W-1:0] obj_idx
);
  localparam int OC_W = $clog2(MAX_OBJECTS + 1);
  logic signed [SUM_W-1:0] csum_r [MAX_CLUSTERS];
  logic [OC_W-1:0] cmem_r [MAX_CLUSTERS];
  logic signed [SUM_W-1:0] osum_r;
  logic [OC_W-1:0] ocnt_r;
  logic [DIST_W-1:0] intra, inter;
  logic [2:0] pred_r;
  logic signed [48:0] num;
  logic [31:0] den;
  logic signed [SIL_W-1:0] sil_r;
  logic div_done;

  always_comb begin
    intra = '0;
    inter = '1;
    for (int j = 0; j < MAX_CLUSTERS; j++) begin
      if (3'(j) == pred) intra = dists[j];
      if (j < int'(cnt) && 3'(j) != pred && dists[j] < inter) inter = dists[j];
    end
    sts.obj_err = ({1'b0, pred} >= cnt) || (ocnt_r >= OC_W'(MAX_OBJECTS));
    sts.div_done = div_done;
  end

  always_comb begin
    if (cmd.sel_avg) begin
      if (cmd.avg_all) begin
        num = 49'(osum_r);
        den = 32'(ocnt_r);
      end else begin
        num = 49'(csum_r[cmd.avg_idx]);
        den = 32'(cmem_r[cmd.avg_idx]);
      end
    end else begin
      num = 49'($signed({1'b0, inter}) - $signed({1'b0, intra})) <<< 16;
      den = (inter > intra) ? inter : intra;
    end
  end

  sss_div u_div (.clk(clk), .rst_n(rst_n), .start(cmd.start_div), .num(num), .den(den),
    .done(div_done), .quo(quo));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      osum_r <= '0;
      ocnt_r <= '0;
      for (int j = 0; j < MAX_CLUSTERS; j++) begin
        csum_r[j] <= '0;
        cmem_r[j] <= '0;
      end
    end else if (cmd.accum) begin
      csum_r[pred_r] <= csum_r[pred_r] + SUM_W'(quo);
      cmem_r[pred_r] <= cmem_r[pred_r] + 1'b1;
      osum_r <= osum_r + SUM_W'(quo);
      ocnt_r <= ocnt_r + 1'b1;
    end
    if (cmd.load_obj) pred_r <= pred;
  end
  assign obj_idx = IDX_W'(ocnt_r);
endmodule

// File: src/sss_ctrl.sv
// Controller state machine sequencing objects and averages.
module sss_ctrl import sss_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic last_in,
  input  logic [3:0] cnt,
  input  sss_sts_t sts,
  output sss_cmd_t cmd,
  output logic busy,
  output logic out_ok,
  output logic [1:0] kind,
  output logic [2:0] avg_idx,
  output logic err,
  output logic is_last
);
  localparam logic [2:0] S_IDLE = 3'd0, S_OBJ = 3'd1, S_AVG_GO = 3'd2, S_AVG = 3'd3,
    S_ALL_GO = 3'd4, S_ALL = 3'd5;
  logic [2:0] st_r, st_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic last_r;

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    cmd = '0;
    cmd.avg_idx = idx_r;
    out_ok = 1'b0;
    kind = KIND_OBJ;
    err = 1'b0;
    is_last = 1'b0;
    unique case (st_r)
      S_IDLE: if (start) begin
        cmd.load_obj = 1'b1;
        idx_nxt = '0;
        if (sts.obj_err) begin
          out_ok = 1'b1;
          err = 1'b1;
          is_last = !last_in;
          st_nxt = last_in ? S_AVG_GO : S_IDLE;
        end else begin
          cmd.start_div = 1'b1;
          st_nxt = S_OBJ;
        end
      end
      S_OBJ: if (sts.div_done) begin
        out_ok = 1'b1;
        cmd.accum = 1'b1;
        is_last = !last_r;
        st_nxt = last_r ? S_AVG_GO : S_IDLE;
      end
      S_AVG_GO: begin
        cmd.sel_avg = 1'b1;
        cmd.start_div = 1'b1;
        st_nxt = S_AVG;
      end
      S_AVG: begin
        cmd.sel_avg = 1'b1;
        if (sts.div_done) begin
          out_ok = 1'b1;
          kind = KIND_CLU;
          idx_nxt = idx_r + 3'd1;
          st_nxt = ({1'b0, idx_r} + 4'd1 >= cnt) ? S_ALL_GO : S_AVG_GO;
        end
      end
      S_ALL_GO: begin
        cmd.sel_avg = 1'b1;
        cmd.avg_all = 1'b1;
        cmd.start_div = 1'b1;
        st_nxt = S_ALL;
      end
      S_ALL: begin
        cmd.sel_avg = 1'b1;
        cmd.avg_all = 1'b1;
        if (sts.div_done) begin
          out_ok = 1'b1;
          kind = KIND_ALL;
          is_last = 1'b1;
          cmd.clear = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
    end
    if (st_r == S_IDLE && start) last_r <= last_in;
  end
  assign busy = (st_r != S_IDLE);
  assign avg_idx = idx_r;
endmodule

// File: src/simplified_silhouette_scorer.sv
// Top level of the simplified silhouette scorer.
// A 48-step shared divider forms each object's silhouette.
// A last object adds one division per cluster in use plus one for the overall
// average. Results appear for one cycle on out_valid and cannot be stalled;
// start is taken only while busy is low. cfg_ready is always high.
module simplified_silhouette_scorer import sss_pkg::*; #(
  parameter int MAX_CLUSTERS = 8,
  parameter int MAX_OBJECTS = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [31:0] in_dist_0, in_dist_1, in_dist_2, in_dist_3,
  input  logic [31:0] in_dist_4, in_dist_5, in_dist_6, in_dist_7,
  input  logic [2:0] in_predicted_cluster,
  input  logic in_last_object,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [3:0] cfg_data,
  output logic out_valid,
  output logic [1:0] out_kind,
  output logic [11:0] out_index,
  output logic signed [17:0] out_silhouette,
  output logic out_status,
  output logic out_last
);
  logic [3:0] ccount_r, cnt;
  logic [31:0] dists [MAX_CLUSTERS];
  logic [31:0] dall [8];
  sss_cmd_t cmd;
  sss_sts_t sts;
  logic ok, err, lst;
  logic [1:0] kind;
  logic [2:0] aidx;
  logic signed [17:0] quo;
  logic [11:0] oidx;

  assign dall = '{in_dist_0, in_dist_1, in_dist_2, in_dist_3,
                  in_dist_4, in_dist_5, in_dist_6, in_dist_7};
  always_comb for (int j = 0; j < MAX_CLUSTERS; j++) dists[j] = dall[j];
  assign cfg_ready = 1'b1;
  always_comb begin
    cnt = ccount_r;
    if (ccount_r < 4'd2) cnt = 4'd2;
    if (ccount_r > 4'(MAX_CLUSTERS)) cnt = 4'(MAX_CLUSTERS);
  end

  sss_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .start(start), .last_in(in_last_object),
    .cnt(cnt), .sts(sts), .cmd(cmd), .busy(busy), .out_ok(ok), .kind(kind),
    .avg_idx(aidx), .err(err), .is_last(lst));

  sss_datapath #(.MAX_CLUSTERS(MAX_CLUSTERS), .MAX_OBJECTS(MAX_OBJECTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .cnt(cnt), .dists(dists),
    .pred(in_predicted_cluster), .quo(quo), .obj_idx(oidx));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccount_r <= 4'd8;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) ccount_r <= cfg_data;
      out_valid <= ok;
    end
    out_kind <= kind;
    out_index <= (kind == KIND_CLU) ? {9'd0, aidx} : (kind == KIND_ALL) ? '0 : oidx;
    out_silhouette <= err ? '0 : quo;
    out_status <= err;
    out_last <= lst;
  end
endmodule

// File: tb/tb_simplified_silhouette_scorer.sv
// Self-checking testbench for the simplified silhouette scorer.
`timescale 1ns / 100ps

module tb_simplified_silhouette_scorer import sss_pkg::*; ();

  localparam int MAX_CL = 8;
  localparam int MAX_OBJ = 4096;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic [31:0] dists[MAX_CL];
    logic [2:0]  pred;
    logic        last_obj;
  } object_t;

  typedef struct {
    logic [1:0]         kind;
    logic [11:0]        index;
    logic signed [17:0] sil;
    logic               status;
    logic               last;
  } score_t;

  logic clk, rst_n;
  logic start, busy;
  logic [31:0] dist_q[MAX_CL];
  logic [2:0] pred_q;
  logic last_q;
  logic cfg_valid, cfg_ready;
  logic [3:0] cfg_data;
  logic out_valid, out_status, out_last;
  logic [1:0] out_kind;
  logic [11:0] out_index;
  logic signed [17:0] out_silhouette;

  simplified_silhouette_scorer i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_dist_0(dist_q[0]), .in_dist_1(dist_q[1]), .in_dist_2(dist_q[2]),
    .in_dist_3(dist_q[3]), .in_dist_4(dist_q[4]), .in_dist_5(dist_q[5]),
    .in_dist_6(dist_q[6]), .in_dist_7(dist_q[7]),
    .in_predicted_cluster(pred_q), .in_last_object(last_q),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_kind(out_kind), .out_index(out_index),
    .out_silhouette(out_silhouette), .out_status(out_status), .out_last(out_last)
  );

  // predictor state
  logic [3:0] cl_count_reg;
  longint cl_sum[MAX_CL];
  int unsigned cl_members[MAX_CL];
  longint all_sum;
  int unsigned obj_count;

  object_t pending_objs[$];
  score_t expected_scores[$];
  int mismatches;
  int idle_pct;
  int stall_cycles;
  bit cfg_pending;
  logic [3:0] cfg_next;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint wrap30(longint v);
    logic [29:0] t;
    t = v[29:0];
    return longint'(signed'(t));
  endfunction

  function automatic longint div_tz(longint num, longint den);
    if (den == 0) return 0;
    return num / den;
  endfunction

  function automatic longint clamp_q(longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic score_t mk(logic [1:0] k, longint idx, longint s, bit st, bit l);
    score_t r;
    r.kind = k;
    r.index = idx[11:0];
    r.sil = s[17:0];
    r.status = st;
    r.last = l;
    return r;
  endfunction

  task automatic predict_scores(object_t o);
    int cnt;
    longint intra, inter, den, sil;
    bit have;
    cnt = cl_count_reg;
    if (cnt < 2) cnt = 2;
    if (cnt > MAX_CL) cnt = MAX_CL;
    if (o.pred >= cnt || obj_count >= MAX_OBJ) begin
      expected_scores.push_back(mk(KIND_OBJ, obj_count, 0, 1'b1, !o.last_obj));
    end else begin
      intra = o.dists[o.pred];
      inter = 0;
      have = 0;
      sil = 0;
      for (int j = 0; j < cnt; j++) begin
        if (j != o.pred && (!have || longint'(o.dists[j]) < inter)) begin
          inter = o.dists[j];
          have = 1;
        end
      end
      if (inter != 0 || intra != 0) begin
        den = (inter > intra) ? inter : intra;
        sil = clamp_q(div_tz((inter - intra) * 65536, den));
      end
      expected_scores.push_back(mk(KIND_OBJ, obj_count, sil, 1'b0, !o.last_obj));
      cl_sum[o.pred] = wrap30(cl_sum[o.pred] + sil);
      cl_members[o.pred]++;
      all_sum = wrap30(all_sum + sil);
      obj_count++;
    end
    if (o.last_obj) begin
      for (int j = 0; j < cnt; j++)
        expected_scores.push_back(mk(KIND_CLU, j,
          clamp_q(div_tz(cl_sum[j], cl_members[j])), 1'b0, 1'b0));
      expected_scores.push_back(mk(KIND_ALL, 0,
        clamp_q(div_tz(all_sum, obj_count)), 1'b0, 1'b1));
      for (int j = 0; j < MAX_CL; j++) begin
        cl_sum[j] = 0;
        cl_members[j] = 0;
      end
      all_sum = 0;
      obj_count = 0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cl_count_reg = cfg_data;
        cfg_valid <= 1'b0;
      end else if (cfg_pending && !cfg_valid) begin
        cfg_data <= cfg_next;
        cfg_valid <= 1'b1;
        cfg_pending = 0;
      end
      if (start && !busy) predict_scores(pending_objs.pop_front());
      if ((!start || !busy) || !(start && !busy)) begin
        if (!start || !busy) begin
          if (pending_objs.size() > 0 && !cfg_valid && !cfg_pending &&
              $urandom_range(99) >= idle_pct) begin
            for (int j = 0; j < MAX_CL; j++) dist_q[j] <= pending_objs[0].dists[j];
            pred_q <= pending_objs[0].pred;
            last_q <= pending_objs[0].last_obj;
            start <= 1'b1;
          end else begin
            start <= 1'b0;
          end
        end
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (out_valid) begin
        if (expected_scores.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction kind=%0d", out_kind);
        end else begin
          score_t e;
          e = expected_scores.pop_front();
          if (e.kind !== out_kind || e.index !== out_index || e.sil !== out_silhouette ||
              e.status !== out_status || e.last !== out_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp k%0d i%0d s%0d st%0d l%0d got k%0d i%0d s%0d st%0d l%0d",
                e.kind, e.index, e.sil, e.status, e.last, out_kind, out_index,
                out_silhouette, out_status, out_last);
          end
        end
      end
    end else begin
      stall_cycles <= 0;
    end
  end

  function automatic logic [31:0] rand_dist();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_obj(logic [31:0] base, bit rnd, logic [2:0] p, bit l);
    object_t o;
    for (int j = 0; j < MAX_CL; j++) o.dists[j] = rnd ? rand_dist() : base;
    o.pred = p;
    o.last_obj = l;
    pending_objs.push_back(o);
  endtask

  task automatic drain();
    while (pending_objs.size() > 0 || expected_scores.size() > 0 || start) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic set_count(logic [3:0] v);
    cfg_next = v;
    cfg_pending = 1;
    while (cfg_pending || cfg_valid) @(posedge clk);
  endtask

  task automatic random_sets(int n_obj, int max_set);
    int k;
    k = 0;
    while (k < n_obj) begin
      int len;
      len = $urandom_range(max_set, 1);
      for (int i = 0; i < len; i++) begin
        logic [2:0] p;
        p = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(cl_count_reg < 2 ?
              1 : (cl_count_reg > 8 ? 7 : cl_count_reg - 1)));
        add_obj(0, 1, p, i == len - 1);
      end
      k += len;
    end
  endtask

  initial begin
    object_t o;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 4'd0;
    pred_q = 3'd0;
    last_q = 1'b0;
    for (int j = 0; j < MAX_CL; j++) begin
      dist_q[j] = 32'd0;
      cl_sum[j] = 0;
      cl_members[j] = 0;
    end
    all_sum = 0;
    obj_count = 0;
    cl_count_reg = 4'd8;
    mismatches = 0;
    idle_pct = 0;
    stall_cycles = 0;
    cfg_pending = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero distances, extremes, bad label, empty set averages
    add_obj(32'd0, 0, 3'd0, 0);
    add_obj(32'hFFFF_FFFF, 0, 3'd7, 0);
    o.dists = '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    o.pred = 3'd0; o.last_obj = 0; pending_objs.push_back(o);
    o.pred = 3'd1; pending_objs.push_back(o);
    o.dists = '{32'h0001_0000, 32'h0000_8000, 32'h5555_AAAA, 32'hAAAA_5555,
                32'h0, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF};
    for (int p = 0; p < 8; p++) begin
      o.pred = 3'(p); o.last_obj = (p == 7); pending_objs.push_back(o);
    end
    add_obj(32'd5, 0, 3'd0, 1);
    drain();

    set_count(4'd2);
    add_obj(0, 1, 3'd0, 0);
    add_obj(0, 1, 3'd2, 0);
    add_obj(0, 1, 3'd7, 1);
    drain();
    set_count(4'd0);
    add_obj(0, 1, 3'd1, 0);
    add_obj(0, 1, 3'd2, 1);
    drain();
    set_count(4'd15);
    add_obj(0, 1, 3'd7, 1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? 51 : 0;
      if (ph == 3) idle_pct = 8;
      set_count(4'($urandom_range(15)));
      random_sets(45, 12);
      drain();
    end

    if (mismatches == 0 && expected_scores.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
